[src/mta_pkg.sv]
// Shared types, register map and limits for the metric threshold alarm.
package mta_pkg;

    localparam int SAMPLE_BITS_DEF = 32;
    localparam int PADDR_W         = 5;
    localparam int PDATA_W         = 32;

    // Condition codes; 7 is unused and behaves like disabled
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_GT  = 3'd0;
    localparam t_kind KIND_LT  = 3'd1;
    localparam t_kind KIND_EQ  = 3'd2;
    localparam t_kind KIND_RNG = 3'd3;
    localparam t_kind KIND_GE  = 3'd4;
    localparam t_kind KIND_LE  = 3'd5;
    localparam t_kind KIND_OFF = 3'd6;

    // Register indexes (byte address / 4)
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_KIND   = 3'd0;
    localparam t_reg_idx REG_DELTA  = 3'd1;
    localparam t_reg_idx REG_THRESH = 3'd2;
    localparam t_reg_idx REG_RLOW   = 3'd3;
    localparam t_reg_idx REG_RHIGH  = 3'd4;
    localparam t_reg_idx REG_HITS   = 3'd5;

    localparam logic [15:0] RUN_MAX    = 16'hFFFF;
    localparam logic [31:0] HITS_MAX   = 32'hFFFF_FFFF;
    localparam logic [15:0] ALERTS_MAX = 16'hFFFF;

    typedef struct packed {
        t_kind       kind;
        logic        delta_en;
        logic [31:0] threshold;
        logic [31:0] range_low;
        logic [31:0] range_high;
        logic [15:0] hits_need;
    } t_cfg;

endpackage

[src/mta_cfg.sv]
// APB register file holding the alarm configuration.
module mta_cfg
    import mta_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = paddr[PADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kind       <= KIND_OFF;
            r_cfg.delta_en   <= 1'b0;
            r_cfg.threshold  <= '0;
            r_cfg.range_low  <= '0;
            r_cfg.range_high <= '0;
            r_cfg.hits_need  <= 16'd1;
        end else if (wr_en) begin
            case (idx)
                REG_KIND:   r_cfg.kind       <= pwdata[2:0];
                REG_DELTA:  r_cfg.delta_en   <= pwdata[0];
                REG_THRESH: r_cfg.threshold  <= pwdata;
                REG_RLOW:   r_cfg.range_low  <= pwdata;
                REG_RHIGH:  r_cfg.range_high <= pwdata;
                REG_HITS:   r_cfg.hits_need  <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_KIND:   prdata = {29'd0, r_cfg.kind};
            REG_DELTA:  prdata = {31'd0, r_cfg.delta_en};
            REG_THRESH: prdata = r_cfg.threshold;
            REG_RLOW:   prdata = r_cfg.range_low;
            REG_RHIGH:  prdata = r_cfg.range_high;
            REG_HITS:   prdata = {16'd0, r_cfg.hits_need};
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[src/mta_front.sv]
// Input register: takes a sample and forms the tested value (raw or delta).
module mta_front
    import mta_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [31:0]            i_sample,
    output logic                   o_ready,
    input  logic                   i_delta_en,
    input  logic                   i_take,
    output logic                   o_valid,
    output logic [SAMPLE_BITS-1:0] o_value
);

    logic                   r_vld;
    logic [SAMPLE_BITS-1:0] r_value;
    logic [SAMPLE_BITS-1:0] r_prev;
    logic [SAMPLE_BITS-1:0] s;
    logic [SAMPLE_BITS-1:0] n_value;
    logic                   accept;

    assign s       = SAMPLE_BITS'(i_sample);
    assign o_ready = !r_vld || i_take;
    assign accept  = i_valid && o_ready;

    // A stored previous sample of zero means no sample yet
    always_comb begin
        if (!i_delta_en) begin
            n_value = s;
        end else if (r_prev == '0) begin
            n_value = '0;
        end else begin
            n_value = s - r_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_prev <= '0;
        end else begin
            if (accept) begin
                r_vld <= 1'b1;
                if (i_delta_en) begin
                    r_prev <= s;
                end
            end else if (i_take) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value <= n_value;
        end
    end

    assign o_valid = r_vld;
    assign o_value = r_value;

endmodule

[src/mta_core.sv]
// Condition test, run and total counters, and the result register.
module mta_core
    import mta_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_valid,
    input  logic [SAMPLE_BITS-1:0] i_value,
    output logic                   o_take,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_met,
    output logic                   o_start,
    output logic                   o_stop,
    output logic [15:0]            o_run,
    output logic [31:0]            o_hits,
    output logic [15:0]            o_alerts
);

    localparam int CW = (SAMPLE_BITS > 32) ? SAMPLE_BITS : 32;

    logic [CW-1:0] v;
    logic [CW-1:0] thr;
    logic [CW-1:0] lo;
    logic [CW-1:0] hi;
    logic          met;
    logic [15:0]   need;
    logic          start;
    logic          stop;
    logic [15:0]   n_run;
    logic [31:0]   n_hits;
    logic [15:0]   n_alerts;

    logic          r_vld;
    logic          r_met;
    logic          r_start;
    logic          r_stop;
    logic [15:0]   r_run;
    logic [31:0]   r_hits;
    logic [15:0]   r_alerts;

    assign v   = CW'(i_value);
    assign thr = CW'(i_cfg.threshold);
    assign lo  = CW'(i_cfg.range_low);
    assign hi  = CW'(i_cfg.range_high);

    always_comb begin
        case (i_cfg.kind)
            KIND_GT:  met = v > thr;
            KIND_LT:  met = v < thr;
            KIND_EQ:  met = v == thr;
            KIND_RNG: met = (v >= lo) && (v <= hi);
            KIND_GE:  met = v >= thr;
            KIND_LE:  met = v <= thr;
            default:  met = 1'b0;
        endcase
    end

    // A hit count of zero acts as one
    assign need = (i_cfg.hits_need == 16'd0) ? 16'd1 : i_cfg.hits_need;

    always_comb begin
        n_run    = r_run;
        n_hits   = r_hits;
        n_alerts = r_alerts;
        start    = 1'b0;
        stop     = 1'b0;
        if (met) begin
            // A saturated run holds and cannot start an alert again
            if (r_run != RUN_MAX) begin
                n_run = r_run + 16'd1;
                start = (n_run == need);
            end
            if (r_hits != HITS_MAX) begin
                n_hits = r_hits + 32'd1;
            end
            if (start && (r_alerts != ALERTS_MAX)) begin
                n_alerts = r_alerts + 16'd1;
            end
        end else begin
            stop  = (r_run >= need);
            n_run = '0;
        end
    end

    assign o_take = i_valid && (!r_vld || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_run    <= '0;
            r_hits   <= '0;
            r_alerts <= '0;
        end else begin
            if (o_take) begin
                r_vld    <= 1'b1;
                r_run    <= n_run;
                r_hits   <= n_hits;
                r_alerts <= n_alerts;
            end else if (i_ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_met   <= met;
            r_start <= start;
            r_stop  <= stop;
        end
    end

    assign o_valid  = r_vld;
    assign o_met    = r_met;
    assign o_start  = r_start;
    assign o_stop   = r_stop;
    assign o_run    = r_run;
    assign o_hits   = r_hits;
    assign o_alerts = r_alerts;

endmodule

[src/metric_threshold_alarm.sv]
// Top level of the metric threshold alarm.
// One sample can be accepted every cycle while the output is not stalled. An accepted
// sample is held in the sample input register (where the delta is formed) and then in
// the result register (behind the condition test and counter update); the two make up
// the whole path, and a stall on the output can hold a sample between them. A full
// result register does not block intake: the input register keeps one more sample until
// the result is taken. No clearing pass follows reset. The configuration registers may be
// written only while no request is in flight.
module metric_threshold_alarm
    import mta_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [31:0]        i_sample,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_condition_met,
    output logic               o_alert_start,
    output logic               o_alert_stop,
    output logic [15:0]        o_run_length,
    output logic [31:0]        o_hit_total,
    output logic [15:0]        o_alert_total
);

    t_cfg                   cfg;
    logic                   take;
    logic                   front_vld;
    logic [SAMPLE_BITS-1:0] front_value;

    mta_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mta_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_sample   (i_sample),
        .o_ready    (o_in_ready),
        .i_delta_en (cfg.delta_en),
        .i_take     (take),
        .o_valid    (front_vld),
        .o_value    (front_value)
    );

    mta_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (front_vld),
        .i_value  (front_value),
        .o_take   (take),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_met    (o_condition_met),
        .o_start  (o_alert_start),
        .o_stop   (o_alert_stop),
        .o_run    (o_run_length),
        .o_hits   (o_hit_total),
        .o_alerts (o_alert_total)
    );

endmodule

[src/mta_checker.sv]
// Port-level checks for the metric threshold alarm, bound to the top level.
module mta_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_condition_met,
    input logic        o_alert_start,
    input logic        o_alert_stop,
    input logic [15:0] o_run_length
);

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result stays up
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped while stalled");

    // An alert only starts on a hit, with a nonzero run
    a_start_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_alert_start) |-> (o_condition_met && o_run_length != 16'd0))
        else $error("alert start without a hit");

    // A miss clears the run; an alert stop only comes with a miss
    a_miss_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (!o_condition_met || o_alert_stop))
            |-> (!o_condition_met && o_run_length == 16'd0))
        else $error("run not cleared on miss");

endmodule

bind metric_threshold_alarm mta_checker u_mta_checker (.*);
